// ===== hw/rtl/bfsp_pkg.sv =====
package bfsp_pkg;

  localparam int unsigned NodeW = 6;
  localparam int unsigned CostW = 24;
  localparam int unsigned DistW = 32;
  localparam int unsigned CountW = 7;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned WeightFracBits = 8;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpAdd   = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;

  localparam logic [1:0] StFound   = 2'd0;
  localparam logic [1:0] StUnreach = 2'd1;
  localparam logic [1:0] StNegCyc  = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic [NodeW-1:0]        edge_source;
    logic [NodeW-1:0]        edge_dest;
    logic signed [CostW-1:0] edge_weight;
    logic [NodeW-1:0]        source_node;
    logic [NodeW-1:0]        target_node;
  } bfsp_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [NodeW-1:0]        path_node;
    logic signed [DistW-1:0] path_cost;
    logic                    last;
  } bfsp_out_t;

  function automatic logic signed [DistW-1:0] sat_add(logic signed [DistW-1:0] a,
                                                      logic signed [CostW-1:0] b);
    logic signed [DistW:0] s;
    s = {a[DistW-1], a} + {{(DistW+1-CostW){b[CostW-1]}}, b};
    if (s[DistW] != s[DistW-1]) begin
      return s[DistW] ? {1'b1, {(DistW-1){1'b0}}} : {1'b0, {(DistW-1){1'b1}}};
    end
    return s[DistW-1:0];
  endfunction

endpackage

// ===== hw/rtl/bellman_ford_shortest_path.sv =====
// bellman-ford shortest path engine
// input channel: in_valid_i / in_stall_o with in_item_i; output channel:
// out_valid_o / out_stall_i with out_item_o; config: cfg_valid_i / cfg_ready_o
// carrying node_count, taken only while idle.
// clear and add items are taken a new one every cycle, but only while idle.
// a query walks the edge store: each edge goes through SPass, SRdE, SRdN
// and SCmp (index check, edge read, distance read, compare and write back).
// a query runs up to node_count passes, capped at 64 (last one only checks),
// then walks predecessors through SWalkR and SWalk per node and emits the
// path source first; each item is read from the path buffer and then loaded
// into the output register once it is free, last flag on the final one.
// reset clears the edge count, sets node_count to 64 and empties the output
// register; memories are not cleared.
// while the receiver stalls the output item holds and the engine waits; no new
// input is taken until the query's last item is in the output register.
module bellman_ford_shortest_path import bfsp_pkg::*; #(
  parameter int unsigned MAX_EDGES = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bfsp_in_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bfsp_out_t       out_item_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  localparam int unsigned NA = $clog2(MaxNodes);
  localparam int unsigned EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);
  localparam int unsigned PW = $clog2(MaxNodes + 1);
  localparam logic [DistW-1:0] Zero = '0;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SPass  = 4'd1;
  localparam logic [3:0] SRdE   = 4'd2;
  localparam logic [3:0] SRdN   = 4'd3;
  localparam logic [3:0] SCmp   = 4'd4;
  localparam logic [3:0] SEndP  = 4'd5;
  localparam logic [3:0] SWalkR = 4'd6;
  localparam logic [3:0] SWalk  = 4'd7;
  localparam logic [3:0] SEmit  = 4'd8;
  localparam logic [3:0] SOne   = 4'd9;
  localparam logic [3:0] SInit  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [CountW-1:0] ncount_q;
  logic [EW-1:0] etotal_q;
  logic [EW-1:0] eidx_q, eidx_d;
  logic [PW-1:0] pass_q, pass_d, npass;
  logic changed_q, changed_d;
  logic checking_q, checking_d;
  logic [MaxNodes-1:0] reached_q, reached_d;
  logic [NA-1:0] src_q, src_d, dst_q, dst_d, cur_q, cur_d;
  logic [PW-1:0] len_q, len_d;
  logic emit_q, emit_d;
  logic signed [DistW-1:0] cost_q, cost_d;
  logic [1:0] one_st_q, one_st_d;
  logic out_valid_q, out_valid_d;
  bfsp_out_t out_q, out_d;
  logic [NodeW-1:0] pbuf_q [MaxNodes];
  logic pb_we;
  logic [NA-1:0] pb_waddr, pb_raddr;
  logic [NodeW-1:0] pb_rdata_q;

  logic [NodeW-1:0] e_from, e_to;
  logic signed [CostW-1:0] e_cost;
  logic [NA-1:0] u_q, v_q;
  logic signed [CostW-1:0] w_q;
  logic signed [DistW-1:0] du, dv;
  logic [NodeW-1:0] pv;
  logic signed [DistW-1:0] cand;
  logic nm_we;
  logic [NA-1:0] nm_waddr, nm_ra, nm_rb;
  logic signed [DistW-1:0] nm_wdist;
  logic [NodeW-1:0] nm_wpred;
  logic in_acc, out_free;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != SIdle);
  assign cfg_ready_o = (state_q == SIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  assign npass = (ncount_q > CountW'(MaxNodes)) ? PW'(MaxNodes) : PW'(ncount_q);

  bfsp_edge_mem #(.AddrW(EA)) u_edges (
    .clk_i, .we_i(in_acc && in_item_i.operation == OpAdd && etotal_q < EW'(MAX_EDGES)),
    .waddr_i(etotal_q[EA-1:0]), .wfrom_i(NodeW'(in_item_i.edge_source[NA-1:0])),
    .wto_i(NodeW'(in_item_i.edge_dest[NA-1:0])), .wcost_i(in_item_i.edge_weight),
    .raddr_i(eidx_q[EA-1:0]), .rfrom_o(e_from), .rto_o(e_to), .rcost_o(e_cost)
  );

  bfsp_node_mem #(.AddrW(NA)) u_nodes (
    .clk_i, .we_i(nm_we), .waddr_i(nm_waddr), .wdist_i(nm_wdist), .wpred_i(nm_wpred),
    .raddr_a_i(nm_ra), .raddr_b_i(nm_rb), .rdist_a_o(du), .rdist_b_o(dv), .rpred_b_o(pv)
  );

  // distances are read in SRdN straight from the edge word, valid in SCmp
  assign nm_ra = (state_q == SRdN) ? e_from[NA-1:0] : u_q;
  assign nm_rb = (state_q == SWalkR || state_q == SWalk) ? cur_q :
                 (state_q == SRdN) ? e_to[NA-1:0] : v_q;
  assign cand = sat_add(du, w_q);

  always_ff @(posedge clk_i) begin
    if (state_q == SRdN) begin
      u_q <= e_from[NA-1:0];
      v_q <= e_to[NA-1:0];
      w_q <= e_cost;
    end else if (state_q == SRdE) begin
      u_q <= u_q;
    end
    if (pb_we) begin
      pbuf_q[pb_waddr] <= NodeW'(cur_q);
    end
    pb_rdata_q <= pbuf_q[pb_raddr];
  end

  always_comb begin
    state_d = state_q;
    eidx_d = eidx_q;
    pass_d = pass_q;
    changed_d = changed_q;
    checking_d = checking_q;
    reached_d = reached_q;
    src_d = src_q;
    dst_d = dst_q;
    cur_d = cur_q;
    len_d = len_q;
    emit_d = emit_q;
    cost_d = cost_q;
    one_st_d = one_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    nm_we = 1'b0;
    nm_waddr = src_q;
    nm_wdist = Zero;
    nm_wpred = '0;
    pb_we = 1'b0;
    pb_waddr = len_q[NA-1:0];
    pb_raddr = NA'(len_q - PW'(1));
    case (state_q)
      SIdle: begin
        if (in_acc && in_item_i.operation == OpQuery) begin
          src_d = in_item_i.source_node[NA-1:0];
          dst_d = in_item_i.target_node[NA-1:0];
          state_d = SInit;
        end
      end
      SInit: begin
        nm_we = 1'b1;
        reached_d = '0;
        reached_d[src_q] = 1'b1;
        pass_d = '0;
        checking_d = (npass <= PW'(1));
        eidx_d = '0;
        changed_d = 1'b0;
        state_d = SPass;
      end
      SPass: begin
        state_d = (eidx_q < etotal_q) ? SRdE : SEndP;
      end
      SRdE: state_d = SRdN;
      SRdN: state_d = SCmp;
      SCmp: begin
        if (reached_q[u_q] && (!reached_q[v_q] || cand < dv)) begin
          changed_d = 1'b1;
          if (!checking_q) begin
            nm_we = 1'b1;
            nm_waddr = v_q;
            nm_wdist = cand;
            nm_wpred = NodeW'(u_q);
            reached_d[v_q] = 1'b1;
          end
        end
        eidx_d = eidx_q + EW'(1);
        state_d = SPass;
      end
      SEndP: begin
        eidx_d = '0;
        changed_d = 1'b0;
        if (checking_q) begin
          if (changed_q) begin
            one_st_d = StNegCyc;
            state_d = SOne;
          end else if (!reached_q[dst_q]) begin
            one_st_d = StUnreach;
            state_d = SOne;
          end else begin
            cur_d = dst_q;
            len_d = '0;
            state_d = SWalkR;
          end
        end else begin
          pass_d = pass_q + PW'(1);
          if (!changed_q || pass_q + PW'(2) >= npass) begin
            checking_d = 1'b1;
          end
          state_d = SPass;
        end
      end
      SWalkR: state_d = SWalk;
      SWalk: begin
        if (cur_q == dst_q && len_q == '0) begin
          cost_d = dv;
        end
        pb_we = 1'b1;
        len_d = len_q + PW'(1);
        if (cur_q == src_q) begin
          emit_d = 1'b0;
          state_d = SEmit;
        end else if (len_q >= PW'(MaxNodes - 1)) begin
          one_st_d = StNegCyc;
          state_d = SOne;
        end else begin
          cur_d = pv[NA-1:0];
          state_d = SWalkR;
        end
      end
      SEmit: begin
        // with emit_q low the buffer is read, with emit_q high the output item is loaded once free
        if (!emit_q) begin
          emit_d = 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d.status = StFound;
          out_d.path_node = pb_rdata_q;
          out_d.path_cost = cost_q;
          out_d.last = (len_q == PW'(1));
          len_d = len_q - PW'(1);
          emit_d = 1'b0;
          if (len_q == PW'(1)) state_d = SIdle;
        end
      end
      SOne: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.status = one_st_q;
          out_d.path_node = '0;
          out_d.path_cost = '0;
          out_d.last = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ncount_q <= CountW'(64);
      etotal_q <= '0;
      out_valid_q <= 1'b0;
      reached_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      reached_q <= reached_d;
      if (cfg_valid_i && cfg_ready_o) ncount_q <= cfg_data_i;
      if (in_acc && in_item_i.operation == OpClear) etotal_q <= '0;
      else if (in_acc && in_item_i.operation == OpAdd && etotal_q < EW'(MAX_EDGES))
        etotal_q <= etotal_q + EW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    eidx_q <= eidx_d;
    pass_q <= pass_d;
    changed_q <= changed_d;
    checking_q <= checking_d;
    src_q <= src_d;
    dst_q <= dst_d;
    cur_q <= cur_d;
    len_q <= len_d;
    emit_q <= emit_d;
    cost_q <= cost_d;
    one_st_q <= one_st_d;
    out_q <= out_d;
  end

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> in_stall_o) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_item_o)) else $error("output changed");
  a_etotal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    etotal_q <= EW'(MAX_EDGES)) else $error("edge count overflow");

endmodule

// ===== hw/rtl/bfsp_edge_mem.sv =====
module bfsp_edge_mem import bfsp_pkg::*; #(
  parameter int unsigned AddrW = 8
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic [NodeW-1:0]        wfrom_i,
  input  logic [NodeW-1:0]        wto_i,
  input  logic signed [CostW-1:0] wcost_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic [NodeW-1:0]        rfrom_o,
  output logic [NodeW-1:0]        rto_o,
  output logic signed [CostW-1:0] rcost_o
);

  logic [2*NodeW+CostW-1:0] mem_q [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wfrom_i, wto_i, wcost_i};
    end
    {rfrom_o, rto_o, rcost_o} <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/bfsp_node_mem.sv =====
module bfsp_node_mem import bfsp_pkg::*; #(
  parameter int unsigned AddrW = 6
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic signed [DistW-1:0] wdist_i,
  input  logic [NodeW-1:0]        wpred_i,
  input  logic [AddrW-1:0]        raddr_a_i,
  input  logic [AddrW-1:0]        raddr_b_i,
  output logic signed [DistW-1:0] rdist_a_o,
  output logic signed [DistW-1:0] rdist_b_o,
  output logic [NodeW-1:0]        rpred_b_o
);

  logic signed [DistW-1:0] dist_q [2**AddrW];
  logic [NodeW-1:0] pred_q [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      dist_q[waddr_i] <= wdist_i;
      pred_q[waddr_i] <= wpred_i;
    end
    rdist_a_o <= dist_q[raddr_a_i];
    rdist_b_o <= dist_q[raddr_b_i];
    rpred_b_o <= pred_q[raddr_b_i];
  end

endmodule
